/* rtl/fmcn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcn_pkg
// shared types and constants of the factor model block
// ----------------------------------------------------------------------------
package fmcn_pkg;
	localparam int MaxOutputs = 64;
	localparam int MaxFactors = 16;
	localparam int RowW = $clog2(MaxOutputs);
	localparam int ColW = $clog2(MaxFactors);
	localparam int AddrW = RowW + ColW;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 7;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_COMMIT = 2'd1,
		CMD_FACTOR = 2'd2,
		CMD_EMIT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_OVER_ONE = 2'd1,
		ST_NOT_COMMITTED = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	localparam logic [CfgIdxW-1:0] CFG_NUM_OUTPUTS = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_NUM_FACTORS = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_SQRT,
		S_RESID,
		S_DONE
	} fsm_t;

	// request from the sequencer to the square root unit
	typedef struct packed {
		logic start;
		logic [32:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic done;
		logic [16:0] root;
	} sqrt_rsp_t;
endpackage

/* rtl/fmcn_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcn_sqrt
// bit-serial square root rounded to nearest, one result bit a cycle
// ----------------------------------------------------------------------------
module fmcn_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  fmcn_pkg::sqrt_req_t req,
	output fmcn_pkg::sqrt_rsp_t rsp
);
	import fmcn_pkg::*;

	logic [33:0] rem_q;
	logic [16:0] root_q;
	logic [33:0] x_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [33:0] trial;
	logic [33:0] rem_sh;

	// restoring method, two radicand bits per step
	assign rem_sh = {rem_q[31:0], x_q[33:32]};
	assign trial = {15'd0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= {1'b0, req.radicand};
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[31:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[15:0], 1'b0};
			end
		end
	end

	// x - r*r > r rounds up; remainder is x - r*r
	assign rsp.done = done_q;
	assign rsp.root = (rem_q > {17'd0, root_q}) ? root_q + 17'd1 : root_q;
endmodule

/* rtl/fmcn_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcn_mac
// registered multiply then accumulate, shared by commit and emit
// ----------------------------------------------------------------------------
module fmcn_mac (
	input  logic clk,
	input  logic clear,
	input  logic en,
	input  logic signed [17:0] a,
	input  logic signed [18:0] b,
	output logic signed [43:0] acc
);
	import fmcn_pkg::*;

	logic signed [37:0] prod_s1;
	logic en_s1;
	logic signed [43:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= 38'(a) * 38'(b);
		en_s1 <= en;
		if (clear)
			acc_q <= '0;
		else if (en_s1)
			acc_q <= acc_q + 44'(prod_s1);
	end

	assign acc = acc_q;
endmodule

/* rtl/factor_model_correlated_normals.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// factor_model_correlated_normals
// linear factor model: correlated normals from loadings, factors, residual
// ----------------------------------------------------------------------------
// load and factor transactions give no result
// commit: F products, then a 17-step square root
// emit: F products from the loading memory, then the residual term
// one item at a time; the loading memory read port paces the walk
// reset clears configuration to one output and one factor, and all commit bits
module factor_model_correlated_normals (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] command,
	input  logic [fmcn_pkg::RowW-1:0] row_index,
	input  logic [fmcn_pkg::ColW-1:0] col_index,
	input  logic signed [17:0] value,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [17:0] result_value,
	output logic [fmcn_pkg::RowW-1:0] out_index,
	output logic [1:0] status,
	output logic last,
	input  logic cfg_we,
	input  logic [fmcn_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [fmcn_pkg::CfgDataW-1:0] cfg_data
);
	import fmcn_pkg::*;

	// memories
	logic signed [17:0] load_mem [MaxOutputs*MaxFactors];
	logic [16:0] wt_mem [MaxOutputs];
	logic signed [17:0] fac_mem [MaxFactors];
	logic [MaxOutputs-1:0] committed_q;

	logic [6:0] nout_q;
	logic [4:0] nfac_q;
	logic [RowW:0] nout_eff;
	logic [ColW:0] nfac_eff;

	fsm_t state_q, state_d;
	logic accept;
	logic [1:0] cmd_q;
	logic [RowW-1:0] row_q;
	logic signed [17:0] val_q;
	logic [ColW:0] j_q;
	logic rd_valid_q;
	logic signed [17:0] ld_rd_q;
	logic signed [17:0] fac_rd_q;
	logic [16:0] wt_rd_q;
	logic [3:0] drain_q;
	logic res_valid_q;
	logic signed [17:0] res_q;
	logic [1:0] st_q;

	// mac controls
	logic mac_clear, mac_en;
	logic signed [17:0] mac_a;
	logic signed [18:0] mac_b;
	logic signed [43:0] acc;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	assign nout_eff = (nout_q == 7'd0) ? (RowW+1)'(1) :
		(nout_q > 7'(MaxOutputs)) ? (RowW+1)'(MaxOutputs) : (RowW+1)'(nout_q);
	assign nfac_eff = (nfac_q == 5'd0) ? (ColW+1)'(1) :
		(nfac_q > 5'(MaxFactors)) ? (ColW+1)'(MaxFactors) : (ColW+1)'(nfac_q);

	// busy while an item is in flight or a result waits
	assign in_stall = (state_q != S_IDLE) || res_valid_q;
	assign accept = in_valid && !in_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nout_q <= 7'd1;
			nfac_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_OUTPUTS: nout_q <= cfg_data;
				CFG_NUM_FACTORS: nfac_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			row_q <= row_index;
			val_q <= value;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (command == CMD_COMMIT || command == CMD_EMIT)) begin
					if ((RowW+1)'(row_index) >= nout_eff)
						state_d = S_DONE;
					else if (command == CMD_EMIT && !committed_q[row_index])
						state_d = S_DONE;
					else
						state_d = S_WALK;
				end
			end
			S_WALK: if (drain_q == 4'd1) state_d = (cmd_q == CMD_COMMIT) ? S_SQRT : S_RESID;
			S_SQRT: if (sq_rsp.done) state_d = S_DONE;
			S_RESID: if (drain_q == 4'd1) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// walk counter; drain waits for memory read and multiply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			drain_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= 1'b0;
			if (state_q == S_IDLE && state_d == S_WALK) begin
				j_q <= '0;
				drain_q <= '0;
			end else if (state_q == S_WALK) begin
				if (j_q < nfac_eff) begin
					j_q <= j_q + 1'b1;
					rd_valid_q <= 1'b1;
					if (j_q == nfac_eff - 1'b1) drain_q <= 4'd3;
				end else if (drain_q != 4'd0) begin
					drain_q <= drain_q - 4'd1;
				end
				if (state_d == S_RESID) drain_q <= 4'd4;
			end else if (state_q == S_RESID) begin
				drain_q <= drain_q - 4'd1;
			end
		end
	end

	// memories: one write, registered reads
	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD)
			load_mem[{row_index, col_index}] <= value;
		if (accept && command == CMD_FACTOR)
			fac_mem[col_index] <= value;
		ld_rd_q <= load_mem[{row_q, j_q[ColW-1:0]}];
		fac_rd_q <= fac_mem[j_q[ColW-1:0]];
		wt_rd_q <= wt_mem[row_q];
		if (state_q == S_SQRT && sq_rsp.done && !acc[32] && acc[31:0] == 32'd0 ||
				state_q == S_SQRT && sq_rsp.done && !(acc > 44'sh100000000))
			wt_mem[row_q] <= sq_rsp.root;
	end

	// commit bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			committed_q <= '0;
		else if (accept && command == CMD_LOAD)
			committed_q[row_index] <= 1'b0;
		else if (state_q == S_SQRT && sq_rsp.done)
			committed_q[row_q] <= !(acc > 44'sh100000000);
	end

	// residual term issued in S_RESID first cycle
	assign mac_clear = (state_q == S_IDLE);
	assign mac_en = rd_valid_q || (state_q == S_RESID && drain_q == 4'd4);
	assign mac_a = (state_q == S_RESID) ? val_q : ld_rd_q;
	assign mac_b = (state_q == S_RESID) ? $signed({2'b00, wt_rd_q}) :
		(cmd_q == CMD_COMMIT) ? 19'(ld_rd_q) : 19'(fac_rd_q);

	fmcn_mac u_mac (
		.clk(clk), .clear(mac_clear), .en(mac_en),
		.a(mac_a), .b(mac_b), .acc(acc)
	);

	// root always runs so an over-one sum still reaches S_DONE; its root is dropped
	assign sq_req.start = (state_q == S_WALK) && (state_d == S_SQRT);
	assign sq_req.radicand = 33'h100000000 - acc[32:0];

	fmcn_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sq_req), .rsp(sq_rsp));

	// rounding and saturation of the emit sum
	logic signed [43:0] rnd;
	logic signed [27:0] sh;
	assign rnd = acc + 44'sd32768;
	assign sh = rnd[43:16];

	// result register, holds until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == S_DONE)
			res_valid_q <= 1'b1;
		else if (res_valid_q && !out_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && state_d == S_DONE) begin
			res_q <= '0;
			st_q <= ST_NOT_COMMITTED;
		end else if (state_q == S_SQRT && sq_rsp.done) begin
			res_q <= '0;
			st_q <= (acc > 44'sh100000000) ? ST_OVER_ONE : ST_OK;
		end else if (state_q == S_WALK && state_d == S_SQRT && (acc > 44'sh100000000)) begin
			res_q <= '0;
			st_q <= ST_OVER_ONE;
		end else if (state_q == S_RESID && state_d == S_DONE) begin
			if (sh > 28'sd131071) begin
				res_q <= 18'sd131071;
				st_q <= ST_SATURATED;
			end else if (sh < -28'sd131072) begin
				res_q <= -18'sd131072;
				st_q <= ST_SATURATED;
			end else begin
				res_q <= sh[17:0];
				st_q <= ST_OK;
			end
		end
	end

	assign out_valid = res_valid_q;
	assign result_value = res_q;
	assign out_index = row_q;
	assign status = st_q;
	assign last = ((RowW+1)'(row_q) == nout_eff - 1'b1);
endmodule

/* rtl/fmcn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcn_checker
// port-level checks of the factor model block
// ----------------------------------------------------------------------------
module fmcn_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [17:0] result_value,
	input logic [1:0] status
);
	import fmcn_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("result dropped under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OVER_ONE || status == ST_NOT_COMMITTED)
		|-> result_value == 18'sd0)
		else $error("error result not zero");
endmodule

bind factor_model_correlated_normals fmcn_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.result_value(result_value), .status(status)
);
